// ===== design/counting_semaphore_table_unit_macros.svh =====
// Assertion macros shared by the semaphore table RTL.
// Included by modules that carry concurrent checks; needs no package.
`ifndef COUNTING_SEMAPHORE_TABLE_UNIT_MACROS_SVH
`define COUNTING_SEMAPHORE_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cst_pkg.sv =====
// Package for the counting semaphore table: command and status codes,
// port widths, parameter defaults and the execute-unit control struct. No dependencies.
`timescale 1ns / 1ps

package cst_pkg;

    localparam int CMD_W    = 3;
    localparam int SLOT_ID_W = 4;
    localparam int INIT_W   = 16;
    localparam int STATUS_W = 2;
    localparam int VAL_W    = 16;

    localparam int SEM_SLOTS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INIT    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WAIT    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POST    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNASSIGNED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SATURATED  = 2'd3;

    // Decisions of the execute unit for one transaction.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                must_block;
        logic                wake_one;
        logic                cnt_we;
        logic                assign_set;
        logic                assign_clr;
    } t_exec_ctl;

endpackage

// ===== design/cst_find.sv =====
// Lowest-free-slot priority encoder over the assigned bits.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module cst_find #(
    parameter int SEM_SLOTS = 16,
    parameter int SLOT_W    = 4
) (
    input  logic [SEM_SLOTS-1:0] i_assigned,
    output logic                 o_found,
    output logic [SLOT_W-1:0]    o_idx
);

    always_comb begin
        o_found = ~&i_assigned;
        o_idx   = '0;
        // Scan downward so the lowest clear bit wins.
        for (int i = SEM_SLOTS - 1; i >= 0; i--) begin
            if (!i_assigned[i]) begin
                o_idx = SLOT_W'(i);
            end
        end
    end

endmodule

// ===== design/cst_exec.sv =====
// Execute unit: decides status, flags and the new counter for one transaction.
// Depends on cst_pkg.
`timescale 1ns / 1ps

module cst_exec #(
    parameter int COUNT_BITS = 16
) (
    input  logic [cst_pkg::CMD_W-1:0]       i_command,
    input  logic                            i_in_range,
    input  logic                            i_assigned,
    input  logic                            i_found,
    input  logic signed [COUNT_BITS-1:0]    i_cur,
    input  logic signed [cst_pkg::INIT_W-1:0] i_init_count,
    output cst_pkg::t_exec_ctl              o_ctl,
    output logic [COUNT_BITS-1:0]           o_new_cnt,
    output logic [cst_pkg::VAL_W-1:0]       o_value
);
    import cst_pkg::*;

    // Common width for comparing the init count with the counter range.
    localparam int EW = (COUNT_BITS > INIT_W) ? COUNT_BITS : INIT_W;
    localparam logic signed [EW-1:0] CMAX_E =
        signed'(EW'({1'b0, {(COUNT_BITS-1){1'b1}}}));
    localparam logic signed [EW-1:0] CMIN_E = ~CMAX_E;
    localparam logic [COUNT_BITS-1:0] ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

    logic                   valid;
    logic signed [EW-1:0]   init_e;
    logic signed [EW-1:0]   cur_e;
    logic signed [EW-1:0]   init_c;
    logic signed [EW-1:0]   new_e;
    logic                   init_sat;
    logic                   at_min;
    logic                   at_max;
    logic                   show_val;

    assign valid  = i_in_range && i_assigned;
    assign init_e = EW'(i_init_count);
    assign cur_e  = EW'(i_cur);
    assign at_min = (cur_e == CMIN_E);
    assign at_max = (cur_e == CMAX_E);

    always_comb begin
        priority if (init_e > CMAX_E) begin
            init_c   = CMAX_E;
            init_sat = 1'b1;
        end else if (init_e < CMIN_E) begin
            init_c   = CMIN_E;
            init_sat = 1'b1;
        end else begin
            init_c   = init_e;
            init_sat = 1'b0;
        end
    end

    always_comb begin
        o_ctl     = '0;
        o_new_cnt = i_cur;
        show_val  = 1'b0;
        unique case (i_command)
            CMD_ALLOC: begin
                if (i_found) begin
                    o_ctl.cnt_we     = 1'b1;
                    o_ctl.assign_set = 1'b1;
                    o_new_cnt        = '0;
                end else begin
                    o_ctl.status = ST_FULL;
                end
            end
            CMD_INIT: begin
                if (!valid) begin
                    o_ctl.status = ST_UNASSIGNED;
                end else begin
                    o_ctl.status = init_sat ? ST_SATURATED : ST_OK;
                    o_ctl.cnt_we = 1'b1;
                    o_new_cnt    = init_c[COUNT_BITS-1:0];
                    show_val     = 1'b1;
                end
            end
            CMD_DESTROY: begin
                if (!valid) begin
                    o_ctl.status = ST_UNASSIGNED;
                end else begin
                    o_ctl.assign_clr = 1'b1;
                end
            end
            CMD_WAIT: begin
                if (!valid) begin
                    o_ctl.status = ST_UNASSIGNED;
                end else begin
                    show_val = 1'b1;
                    if (at_min) begin
                        o_ctl.status = ST_SATURATED;
                    end else begin
                        o_ctl.cnt_we = 1'b1;
                        o_new_cnt    = i_cur - ONE;
                    end
                    o_ctl.must_block = o_new_cnt[COUNT_BITS-1];
                end
            end
            CMD_POST: begin
                if (!valid) begin
                    o_ctl.status = ST_UNASSIGNED;
                end else begin
                    show_val = 1'b1;
                    if (at_max) begin
                        o_ctl.status = ST_SATURATED;
                    end else begin
                        o_ctl.cnt_we = 1'b1;
                        o_new_cnt    = i_cur + ONE;
                    end
                    o_ctl.wake_one = o_new_cnt[COUNT_BITS-1] || (o_new_cnt == '0);
                end
            end
            default: begin
                // unused command codes: no effect
            end
        endcase
    end

    assign new_e   = EW'(signed'(o_new_cnt));
    assign o_value = show_val ? new_e[VAL_W-1:0] : '0;

endmodule

// ===== design/counting_semaphore_table_unit.sv =====
// Counting semaphore table top level: input register, counter memory,
// assigned bits, execute stage and result register.
// Depends on cst_pkg, cst_find, cst_exec and the assertion macro header.
`timescale 1ns / 1ps
`include "counting_semaphore_table_unit_macros.svh"

// Usage
// - Command channel: drive i_command, i_slot_id and i_init_count and raise
//   start; the transaction is taken at a rising edge with start high and
//   busy low. busy is held low, so one command can be issued every cycle.
// - Result channel: o_done is high for exactly one cycle with o_status,
//   o_granted_slot, o_must_block, o_wake_one and o_counter_value. The
//   receiver cannot stall; it must take the result in that cycle.
// - Path: a command taken at a rising edge passes through the stage 1
//   and result registers in turn. Throughput is one transaction per cycle.
// - Stage 1 registers the command and reads the counter memory (one read
//   port, registered). Stage 2 runs the execute unit and the free-slot
//   encoder, writes back, and registers the result.
// - A command hitting the slot written by the one just ahead of it gets the
//   fresh value through a forwarding register, since the memory read in
//   stage 1 happens on the same edge as that write.
// - Reset (i_rst_n low, synchronous) frees every slot. Counter contents are
//   undefined until alloc or init writes them; no clearing pass is run.
module counting_semaphore_table_unit #(
    parameter int SEM_SLOTS  = cst_pkg::SEM_SLOTS_DEF,
    parameter int COUNT_BITS = cst_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [cst_pkg::CMD_W-1:0]           i_command,
    input  logic [cst_pkg::SLOT_ID_W-1:0]       i_slot_id,
    input  logic signed [cst_pkg::INIT_W-1:0]   i_init_count,
    output logic                                o_done,
    output logic [cst_pkg::STATUS_W-1:0]        o_status,
    output logic [cst_pkg::SLOT_ID_W-1:0]       o_granted_slot,
    output logic                                o_must_block,
    output logic                                o_wake_one,
    output logic signed [cst_pkg::VAL_W-1:0]    o_counter_value
);
    import cst_pkg::*;

    localparam int SLOT_W = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;

    // Counter store: one write port (stage 2), one registered read (stage 1).
    logic [COUNT_BITS-1:0]  mem [SEM_SLOTS];

    logic                   accept;
    logic [SLOT_W-1:0]      in_addr;
    logic                   in_range;

    // Stage 1 registers
    logic                   r_v;
    logic [CMD_W-1:0]       r_cmd;
    logic [SLOT_ID_W-1:0]   r_slot_id;
    logic [SLOT_W-1:0]      r_addr;
    logic                   r_in_range;
    logic signed [INIT_W-1:0] r_init;
    logic [COUNT_BITS-1:0]  r_rd;
    logic                   r_fwd;
    logic [COUNT_BITS-1:0]  r_fwd_val;

    // Slot ownership
    logic [SEM_SLOTS-1:0]   r_assigned;
    logic [SEM_SLOTS-1:0]   n_assigned;

    // Stage 2 signals
    logic                   found;
    logic [SLOT_W-1:0]      free_idx;
    logic                   cur_assigned;
    logic [COUNT_BITS-1:0]  cur_cnt;
    t_exec_ctl              ctl;
    logic [COUNT_BITS-1:0]  new_cnt;
    logic [VAL_W-1:0]       value;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    logic [SLOT_ID_W-1:0]   granted;

    // Result registers
    logic                   r_done;
    logic [STATUS_W-1:0]    r_status;
    logic [SLOT_ID_W-1:0]   r_granted;
    logic                   r_block;
    logic                   r_wake;
    logic [VAL_W-1:0]       r_value;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign in_addr  = SLOT_W'(i_slot_id);
    assign in_range = (32'(i_slot_id) < SEM_SLOTS);

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= i_command;
            r_slot_id  <= i_slot_id;
            r_addr     <= in_addr;
            r_in_range <= in_range;
            r_init     <= i_init_count;
            r_rd       <= mem[in_addr];
            // The memory read sees the old word when stage 2 writes the
            // same slot on this edge; keep the written word instead.
            r_fwd      <= wr_en && (wr_addr == in_addr);
            r_fwd_val  <= new_cnt;
        end
    end

    // ---------------- stage 2 ----------------
    cst_find #(
        .SEM_SLOTS (SEM_SLOTS),
        .SLOT_W    (SLOT_W)
    ) u_find (
        .i_assigned (r_assigned),
        .o_found    (found),
        .o_idx      (free_idx)
    );

    assign cur_assigned = r_in_range && r_assigned[r_addr];
    assign cur_cnt      = r_fwd ? r_fwd_val : r_rd;

    cst_exec #(
        .COUNT_BITS (COUNT_BITS)
    ) u_exec (
        .i_command    (r_cmd),
        .i_in_range   (r_in_range),
        .i_assigned   (cur_assigned),
        .i_found      (found),
        .i_cur        (signed'(cur_cnt)),
        .i_init_count (r_init),
        .o_ctl        (ctl),
        .o_new_cnt    (new_cnt),
        .o_value      (value)
    );

    // alloc targets the lowest free slot, everything else the addressed one
    assign wr_addr = (r_cmd == CMD_ALLOC) ? free_idx : r_addr;
    assign wr_en   = r_v && ctl.cnt_we;

    always_comb begin
        if (r_cmd == CMD_ALLOC) begin
            granted = found ? SLOT_ID_W'(free_idx) : '0;
        end else begin
            granted = r_slot_id;
        end
    end

    always_comb begin
        n_assigned = r_assigned;
        if (r_v && ctl.assign_set) begin
            n_assigned[wr_addr] = 1'b1;
        end
        if (r_v && ctl.assign_clr) begin
            n_assigned[wr_addr] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_assigned <= '0;
        end else begin
            r_assigned <= n_assigned;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= new_cnt;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v) begin
            r_status  <= ctl.status;
            r_granted <= granted;
            r_block   <= ctl.must_block;
            r_wake    <= ctl.wake_one;
            r_value   <= value;
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_granted_slot  = r_granted;
    assign o_must_block    = r_block;
    assign o_wake_one      = r_wake;
    assign o_counter_value = signed'(r_value);

    // ---------------- checks ----------------
    `CST_ASSERT_NXT(a_done_follows, i_clk, i_rst_n, r_v, o_done, "accepted transaction lost")
    `CST_ASSERT_IMP(a_full_only_when_full, i_clk, i_rst_n, r_v && (r_cmd == CMD_ALLOC) && !found, &r_assigned, "table full reported with a free slot")
    `CST_ASSERT_NXT(a_one_alloc_per_cycle, i_clk, i_rst_n, 1'b1, $countones(r_assigned) <= $past($countones(r_assigned)) + 1, "more than one slot claimed in a cycle")
    `CST_ASSERT_IMP(a_flags_exclusive, i_clk, i_rst_n, o_done, !(o_must_block && o_wake_one), "block and wake raised together")
    `CST_ASSERT_IMP(a_full_grants_zero, i_clk, i_rst_n, o_done && (o_status == ST_FULL), o_granted_slot == '0, "table full with nonzero slot")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for counting_semaphore_table_unit: queued command driver,
// result monitor and a cycle-free predictor of the slot table.
// Depends on cst_pkg and the unit RTL; reads no files.
`timescale 1ns / 1ps

module tb_top;
    import cst_pkg::*;

    localparam int N_SLOTS = 16;
    localparam logic signed [VAL_W-1:0] CNT_MAX = 16'sh7FFF;
    localparam logic signed [VAL_W-1:0] CNT_MIN = 16'sh8000;
    localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
    localparam int RAND_OPS   = 550;

    // One queued command transaction plus its pacing.
    typedef struct {
        logic [CMD_W-1:0]            cmd;
        logic [SLOT_ID_W-1:0]        slot;
        logic signed [INIT_W-1:0]    count;
        int                          gap;    // idle cycles before issue
        bit                          drain;  // hold until all results are back
    } t_sem_op;

    // One result transaction.
    typedef struct {
        logic [STATUS_W-1:0]         status;
        logic [SLOT_ID_W-1:0]        granted;
        logic                        blk;
        logic                        wake;
        logic signed [VAL_W-1:0]     value;
    } t_sem_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [CMD_W-1:0]             i_command = '0;
    logic [SLOT_ID_W-1:0]         i_slot_id = '0;
    logic signed [INIT_W-1:0]     i_init_count = '0;
    logic                         o_done;
    logic [STATUS_W-1:0]          o_status;
    logic [SLOT_ID_W-1:0]         o_granted_slot;
    logic                         o_must_block;
    logic                         o_wake_one;
    logic signed [VAL_W-1:0]      o_counter_value;

    counting_semaphore_table_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_slot_id       (i_slot_id),
        .i_init_count    (i_init_count),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_granted_slot  (o_granted_slot),
        .o_must_block    (o_must_block),
        .o_wake_one      (o_wake_one),
        .o_counter_value (o_counter_value)
    );

    t_sem_op     cmd_q[$];      // commands not yet issued
    t_sem_result result_q[$];   // predicted results, oldest first
    int          errors = 0;
    bit          took_cmd = 1'b0;
    int          idle_cnt = 0;

    // Predictor state: counters and assigned bits as the table should hold them.
    logic signed [VAL_W-1:0] sem_cnt [N_SLOTS];
    bit                      sem_used [N_SLOTS];

    // Generator-side shadow of the assigned bits, used only to aim commands
    // at live slots. Alloc and destroy outcomes do not depend on counters.
    bit gen_used [N_SLOTS];
    int gen_gap_max = 16;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Safety net: timeout far above the slowest legal run.
    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor. Applies one command to the table copy and returns the
    // result the unit must report for it.
    // ------------------------------------------------------------------
    function automatic t_sem_result apply_sem_op(logic [CMD_W-1:0] cmd,
                                                 logic [SLOT_ID_W-1:0] slot,
                                                 logic signed [INIT_W-1:0] cnt_in);
        t_sem_result r;
        bit          found;
        r.status  = ST_OK;
        r.granted = slot;
        r.blk     = 1'b0;
        r.wake    = 1'b0;
        r.value   = '0;
        found     = 1'b0;
        if (cmd == CMD_ALLOC) begin
            // lowest free slot wins; counter starts at zero
            r.status  = ST_FULL;
            r.granted = '0;
            for (int i = 0; i < N_SLOTS; i++) begin
                if (!found && !sem_used[i]) begin
                    found       = 1'b1;
                    sem_used[i] = 1'b1;
                    sem_cnt[i]  = '0;
                    r.status    = ST_OK;
                    r.granted   = i[SLOT_ID_W-1:0];
                end
            end
        end else if (cmd == CMD_INIT || cmd == CMD_DESTROY ||
                     cmd == CMD_WAIT || cmd == CMD_POST) begin
            if (!sem_used[slot]) begin
                r.status = ST_UNASSIGNED;
            end else if (cmd == CMD_INIT) begin
                // 16-bit count fits a 16-bit counter: clamp can never fire here
                sem_cnt[slot] = cnt_in;
                r.value       = cnt_in;
            end else if (cmd == CMD_DESTROY) begin
                sem_used[slot] = 1'b0;
                sem_cnt[slot]  = '0;
            end else if (cmd == CMD_WAIT) begin
                if (sem_cnt[slot] == CNT_MIN)
                    r.status = ST_SATURATED;
                else
                    sem_cnt[slot] = sem_cnt[slot] - 16'sd1;
                r.value = sem_cnt[slot];
                r.blk   = r.value[VAL_W-1];
            end else begin
                if (sem_cnt[slot] == CNT_MAX)
                    r.status = ST_SATURATED;
                else
                    sem_cnt[slot] = sem_cnt[slot] + 16'sd1;
                r.value = sem_cnt[slot];
                // waiters existed when the count is still at or below zero
                r.wake  = r.value[VAL_W-1] || (r.value == '0);
            end
        end
        // reserved codes: no change, all-zero result except the slot echo
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_op(logic [CMD_W-1:0] cmd, logic [SLOT_ID_W-1:0] slot,
                            logic signed [INIT_W-1:0] count, bit drain);
        t_sem_op op;
        bit      found;
        found    = 1'b0;
        op.cmd   = cmd;
        op.slot  = slot;
        op.count = count;
        op.gap   = $urandom_range(0, gen_gap_max);
        op.drain = drain;
        cmd_q.push_back(op);
        if (cmd == CMD_ALLOC) begin
            for (int i = 0; i < N_SLOTS; i++) begin
                if (!found && !gen_used[i]) begin
                    found       = 1'b1;
                    gen_used[i] = 1'b1;
                end
            end
        end else if (cmd == CMD_DESTROY) begin
            gen_used[slot] = 1'b0;
        end
    endtask

    // Mostly a live slot, sometimes any slot.
    function automatic logic [SLOT_ID_W-1:0] pick_slot();
        int live[$];
        for (int i = 0; i < N_SLOTS; i++)
            if (gen_used[i])
                live.push_back(i);
        if (live.size() > 0 && $urandom_range(0, 99) < 85)
            return SLOT_ID_W'(live[$urandom_range(0, live.size() - 1)]);
        return SLOT_ID_W'($urandom_range(0, N_SLOTS - 1));
    endfunction

    // Counts cluster near the rails so saturation gets exercised.
    function automatic logic signed [INIT_W-1:0] pick_count();
        int sel;
        sel = $urandom_range(0, 3);
        case (sel)
            0:       return INIT_W'(CNT_MAX - $urandom_range(0, 3));
            1:       return INIT_W'(CNT_MIN + $urandom_range(0, 3));
            2:       return INIT_W'($urandom_range(0, 6) - 3);
            default: return INIT_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: inputs move on the falling edge only, one NBA per signal.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        bit      nxt_start;
        t_sem_op op;
        nxt_start = start;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
            idle_cnt  = 0;
        end else begin
            if (start && took_cmd)
                nxt_start = 1'b0;
            if (!nxt_start) begin
                if (cmd_q.size() > 0 && idle_cnt >= cmd_q[0].gap &&
                    !(cmd_q[0].drain && result_q.size() != 0)) begin
                    op        = cmd_q.pop_front();
                    nxt_start = 1'b1;
                    idle_cnt  = 0;
                end else begin
                    idle_cnt++;
                end
            end
        end
        if (nxt_start && !(start && !took_cmd)) begin
            i_command    <= op.cmd;
            i_slot_id    <= op.slot;
            i_init_count <= op.count;
        end else if (!nxt_start) begin
            // junk on the fields while idle; the unit must ignore it
            i_command    <= CMD_W'($urandom_range(0, 7));
            i_slot_id    <= SLOT_ID_W'($urandom_range(0, N_SLOTS - 1));
            i_init_count <= INIT_W'($urandom_range(0, 16'hFFFF));
        end
        start <= nxt_start;
    end

    // ------------------------------------------------------------------
    // Monitor: samples at the rising edge, checks results, then predicts
    // for a transaction taken at this edge.
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h",
                     $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_sem_result want;
        took_cmd = i_rst_n && start && !busy;
        if (i_rst_n && o_done !== 1'b0) begin
            if (result_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual status %h slot %h",
                         $time, o_status, o_granted_slot);
            end else begin
                want = result_q.pop_front();
                check_field("done",          16'(1'b1),          16'(o_done));
                check_field("status",        16'(want.status),   16'(o_status));
                check_field("granted_slot",  16'(want.granted),  16'(o_granted_slot));
                check_field("must_block",    16'(want.blk),      16'(o_must_block));
                check_field("wake_one",      16'(want.wake),     16'(o_wake_one));
                check_field("counter_value", want.value,         o_counter_value);
            end
        end
        if (took_cmd)
            result_q.push_back(apply_sem_op(i_command, i_slot_id, i_init_count));
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int n_rand;
        int alloc_w;
        int plen;
        int r;
        logic [CMD_W-1:0] c;

        for (int i = 0; i < N_SLOTS; i++) begin
            sem_used[i] = 1'b0;
            sem_cnt[i]  = '0;
            gen_used[i] = 1'b0;
        end

        // directed: errors on an empty table, rails, flag edges, slot reuse
        queue_op(CMD_WAIT,    4'd0,  16'sd0,     1'b0);
        queue_op(CMD_POST,    4'd15, 16'sd0,     1'b0);
        queue_op(CMD_INIT,    4'd9,  CNT_MAX,    1'b0);
        queue_op(CMD_DESTROY, 4'd3,  16'sd0,     1'b0);
        queue_op(CMD_ALLOC,   4'd7,  16'sd0,     1'b0);
        queue_op(CMD_INIT,    4'd0,  CNT_MIN,    1'b0);
        queue_op(CMD_WAIT,    4'd0,  16'sd0,     1'b0);   // saturates low
        queue_op(CMD_POST,    4'd0,  16'sd0,     1'b0);
        queue_op(CMD_INIT,    4'd0,  CNT_MAX,    1'b0);
        queue_op(CMD_POST,    4'd0,  16'sd0,     1'b0);   // saturates high
        queue_op(CMD_WAIT,    4'd0,  16'sd0,     1'b0);
        queue_op(CMD_INIT,    4'd0,  16'sd0,     1'b1);
        queue_op(CMD_WAIT,    4'd0,  16'sd0,     1'b0);   // goes to -1: block
        queue_op(CMD_POST,    4'd0,  16'sd0,     1'b0);   // back to 0: wake
        queue_op(CMD_POST,    4'd0,  16'sd0,     1'b0);   // 1: no wake
        queue_op(CMD_ALLOC,   4'd0,  16'sd0,     1'b0);
        queue_op(CMD_DESTROY, 4'd0,  16'sd0,     1'b0);
        queue_op(CMD_ALLOC,   4'd15, -16'sd1,    1'b0);   // reuses slot 0
        queue_op(CMD_RSVD_5,  4'd1,  CNT_MIN,    1'b0);
        queue_op(CMD_RSVD_6,  4'd10, CNT_MAX,    1'b0);
        queue_op(CMD_RSVD_7,  4'd5,  -16'sd1,    1'b0);
        queue_op(CMD_DESTROY, 4'd1,  16'sd0,     1'b0);
        queue_op(CMD_POST,    4'd1,  16'sd0,     1'b0);   // freed slot

        // random: phases of varying alloc pressure; first one fills the table
        n_rand = 0;
        while (n_rand < RAND_OPS) begin
            if (n_rand == 0) begin
                alloc_w = 100;
                plen    = 18;
            end else begin
                r       = $urandom_range(0, 2);
                alloc_w = (r == 0) ? 4 : (r == 1) ? 20 : 55;
                plen    = $urandom_range(20, 60);
            end
            gen_gap_max = ($urandom_range(0, 99) < 30) ? 0 : 16;
            for (int k = 0; k < plen; k++) begin
                if ($urandom_range(0, 99) < alloc_w) begin
                    c = CMD_ALLOC;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 4)       c = CMD_W'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
                    else if (r < 12) c = CMD_DESTROY;
                    else if (r < 27) c = CMD_INIT;
                    else if (r < 63) c = CMD_WAIT;
                    else             c = CMD_POST;
                end
                // occasional full drain before a command, and at phase start
                queue_op(c, pick_slot(), pick_count(),
                         k == 0 || $urandom_range(0, 99) < 2);
                n_rand++;
            end
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (cmd_q.size() != 0 || start || result_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
